>>> sv/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int PAT_WORDS       = 4;
    localparam int PAT_BYTES       = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_W           = 6;

    localparam logic [31:0]    LIMIT_RESET = 32'd30_000_000;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_WORD_0 = 3'd0,
        REG_PAT_WORD_1 = 3'd1,
        REG_PAT_WORD_2 = 3'd2,
        REG_PAT_WORD_3 = 3'd3,
        REG_WILD_MASK  = 3'd4,
        REG_PAT_LEN    = 3'd5,
        REG_LIMIT      = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [PAT_WORDS-1:0][63:0] pat_word;
        logic [31:0]                wild_mask;
        logic [LEN_W-1:0]           pat_len;
        logic [31:0]                limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [63:0] byte_address;
        logic        region_start;
        logic        scan_start;
    } t_in_beat;

    typedef struct packed {
        logic        hit;
        logic [63:0] match_address;
        logic [63:0] captured;
    } t_match;

endpackage

>>> sv/wbps_cfg_regs.sv
// Configuration register file of the scanner.
module wbps_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output wbps_pkg::t_cfg                    o_cfg
);

    wbps_pkg::t_cfg r_cfg;
    wbps_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (wbps_pkg::t_reg_idx'(i_cfg_addr))
                wbps_pkg::REG_PAT_WORD_0: n_cfg.pat_word[0] = i_cfg_data;
                wbps_pkg::REG_PAT_WORD_1: n_cfg.pat_word[1] = i_cfg_data;
                wbps_pkg::REG_PAT_WORD_2: n_cfg.pat_word[2] = i_cfg_data;
                wbps_pkg::REG_PAT_WORD_3: n_cfg.pat_word[3] = i_cfg_data;
                wbps_pkg::REG_WILD_MASK:  n_cfg.wild_mask   = i_cfg_data[31:0];
                wbps_pkg::REG_PAT_LEN:
                    n_cfg.pat_len = i_cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::REG_LIMIT:      n_cfg.limit       = i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_word  <= '0;
            r_cfg.wild_mask <= '0;
            r_cfg.pat_len   <= wbps_pkg::LEN_RESET;
            r_cfg.limit     <= wbps_pkg::LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/wbps_history.sv
// Byte history shift register with its fill count.
module wbps_history #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int HIST_D      = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1,
    parameter int FILL_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic                   i_clear,
    input  logic [7:0]             i_byte,
    output logic [HIST_D-1:0][7:0] o_hist,
    output logic [FILL_W-1:0]      o_fill
);

    logic [HIST_D-1:0][7:0] r_hist;
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic [FILL_W-1:0]      fill_base;

    generate
        if (PATTERN_MAX > 1) begin : g_hist
            localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX - 1);

            always_comb begin
                fill_base = i_clear ? '0 : r_fill;
                n_fill    = r_fill;
                if (i_shift) begin
                    n_fill = (fill_base == FILL_MAX) ? FILL_MAX : fill_base + 1'b1;
                end else if (i_clear) begin
                    n_fill = '0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_shift) begin
                    r_hist[0] <= i_byte;
                    for (int k = 1; k < HIST_D; k++) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                end
            end
        end else begin : g_no_hist
            always_comb begin
                fill_base = '0;
                n_fill    = '0;
            end

            always_ff @(posedge i_clk) begin
                if (i_shift) begin
                    r_hist <= '0;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_hist = r_hist;
    assign o_fill = r_fill;

endmodule

>>> sv/wbps_match.sv
// Window compare against the wildcard pattern and capture of the matched bytes.
module wbps_match #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int HIST_D      = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1,
    parameter int FILL_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  wbps_pkg::t_cfg         i_cfg,
    input  logic [7:0]             i_cur,
    input  logic [63:0]            i_addr,
    input  logic [HIST_D-1:0][7:0] i_hist,
    input  logic [FILL_W-1:0]      i_fill,
    output wbps_pkg::t_match       o_match
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [wbps_pkg::LEN_W-1:0] PM_LEN = wbps_pkg::LEN_W'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0][7:0]          age_byte;
    logic [wbps_pkg::PAT_BYTES-1:0][7:0]  pat_byte;
    logic [wbps_pkg::LEN_W-1:0]           len;
    logic [PATTERN_MAX-1:0]               ok;
    logic                                 fill_ok;
    logic [63:0]                          captured;

    // Age 0 is the current byte, age k is history entry k-1.
    generate
        for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_age
            if (j == 0) begin : g_cur
                assign age_byte[j] = i_cur;
            end else begin : g_old
                assign age_byte[j] = i_hist[j-1];
            end
        end
        for (genvar k = 0; k < wbps_pkg::PAT_BYTES; k++) begin : g_pat
            assign pat_byte[k] = i_cfg.pat_word[k/8][(k%8)*8 +: 8];
        end
    endgenerate

    always_comb begin
        if (i_cfg.pat_len == '0) begin
            len = wbps_pkg::LEN_W'(1);
        end else if (i_cfg.pat_len > PM_LEN) begin
            len = PM_LEN;
        end else begin
            len = i_cfg.pat_len;
        end
    end

    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] pidx;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            pidx  = len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
            ok[j] = (wbps_pkg::LEN_W'(j) >= len) || i_cfg.wild_mask[pidx[4:0]]
                    || (age_byte[j] == pat_byte[pidx[4:0]]);
        end
    end

    assign fill_ok = (wbps_pkg::LEN_W'(i_fill) + wbps_pkg::LEN_W'(1)) >= len;

    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] age;
        captured = '0;
        for (int i = 0; i < 8; i++) begin
            age = len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(i);
            if (wbps_pkg::LEN_W'(i) < len) begin
                captured[i*8 +: 8] = age_byte[age[IDX_W-1:0]];
            end
        end
    end

    assign o_match.captured      = captured;
    assign o_match.hit           = fill_ok && (&ok);
    assign o_match.match_address = i_addr - 64'(len - wbps_pkg::LEN_W'(1));

endmodule

>>> sv/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner.
// The block scans a stream of memory bytes for a pattern of up to PATTERN_MAX bytes,
// any of which may be a wildcard. Each slave beat carries one byte and its address;
// tuser marks a region start (history cleared) or a scan start (count, stop flag and
// history cleared). Each match gives one master beat with the address of the first
// matched byte and up to eight matched bytes. Once the match limit is reached, the
// next match gives one beat with the overflow flag in tuser and the block drops bytes
// until a beat with scan start arrives.
// Registers are written through the plain write port while the stream is idle; the
// user must keep to this, the block does not enforce it. A beat is taken into an
// input register and compared in the next cycle against the history register; the
// result register is loaded when the beat steps on, which waits while a held result
// is not taken. One beat is taken each cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register fills,
// after which s_axis_tready drops until the result is taken.
// Reset clears the history fill, the match count, the stop flag and all valid flags,
// and loads the register reset values.
module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: byte_value [7:0], byte_address [71:8].
    input  logic [71:0]                      s_axis_tdata,
    // tuser: region_start [0], scan_start [1].
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: match_address [63:0], captured_bytes [127:64].
    output logic [127:0]                     m_axis_tdata,
    // tuser: overflow [0].
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int HIST_D = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int FILL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    wbps_pkg::t_cfg         cfg;
    wbps_pkg::t_in_beat     r_in;
    logic                   r_in_valid;
    logic                   r_out_valid;
    logic [127:0]           r_out_data;
    logic                   r_out_ovf;
    logic [31:0]            r_count;
    logic                   r_stop;
    logic [31:0]            n_count;
    logic                   n_stop;
    logic                   step;
    logic                   clear;
    logic                   stopped_eff;
    logic [31:0]            count_eff;
    logic                   produce;
    logic                   over;
    logic [HIST_D-1:0][7:0] hist;
    logic [FILL_W-1:0]      fill;
    logic [FILL_W-1:0]      fill_eff;
    wbps_pkg::t_match       match;

    wbps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.byte_value   <= s_axis_tdata[7:0];
            r_in.byte_address <= s_axis_tdata[71:8];
            r_in.region_start <= s_axis_tuser[0];
            r_in.scan_start   <= s_axis_tuser[1];
        end
    end

    assign clear       = r_in.region_start || r_in.scan_start;
    assign stopped_eff = r_stop && !r_in.scan_start;
    assign count_eff   = r_in.scan_start ? '0 : r_count;
    assign fill_eff    = clear ? '0 : fill;

    wbps_history #(
        .PATTERN_MAX (PATTERN_MAX),
        .HIST_D      (HIST_D),
        .FILL_W      (FILL_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (step && !stopped_eff),
        .i_clear (step && clear),
        .i_byte  (r_in.byte_value),
        .o_hist  (hist),
        .o_fill  (fill)
    );

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .HIST_D      (HIST_D),
        .FILL_W      (FILL_W)
    ) u_match (
        .i_cfg   (cfg),
        .i_cur   (r_in.byte_value),
        .i_addr  (r_in.byte_address),
        .i_hist  (hist),
        .i_fill  (fill_eff),
        .o_match (match)
    );

    assign produce = step && !stopped_eff && match.hit;
    assign over    = count_eff >= cfg.limit;

    always_comb begin
        n_count = r_count;
        n_stop  = r_stop;
        if (step && r_in.scan_start) begin
            n_count = '0;
            n_stop  = 1'b0;
        end
        if (produce) begin
            if (over) begin
                n_stop = 1'b1;
            end else begin
                n_count = count_eff + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_stop  <= n_stop;
            if (step) begin
                r_out_valid <= produce;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out_ovf  <= over;
            r_out_data <= over ? '0 : {match.captured, match.match_address};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ovf;

endmodule
